// ===== design/bfsk_pkg.sv =====
// Shared constants, types and the cosine table of the binary FSK tone modulator.
package bfsk_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int TAB_ADDR_BITS = 8;
  localparam int AMPLITUDE     = 32767;
  localparam int TAB_SIZE      = 1 << TAB_ADDR_BITS;
  localparam int MAG_BITS      = 15;
  localparam int SAMPLE_BITS   = 16;
  localparam int SPB_BITS      = 16;
  localparam int PAD_BITS      = 8;
  localparam int BYTE_BITS     = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [PHASE_BITS-1:0] PAD_STEP_RST   = PHASE_BITS'(38956620);
  localparam logic [PHASE_BITS-1:0] SPACE_STEP_RST = PHASE_BITS'(194783097);
  localparam logic [PHASE_BITS-1:0] MARK_STEP_RST  = PHASE_BITS'(584349292);
  localparam logic [SPB_BITS-1:0]   SPB_RST        = SPB_BITS'(1100);
  localparam logic [PAD_BITS-1:0]   PAD_BYTES_RST  = PAD_BITS'(5);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PAD_STEP        = 3'd0,
    REG_SPACE_STEP      = 3'd1,
    REG_MARK_STEP       = 3'd2,
    REG_SAMPLES_PER_BIT = 3'd3,
    REG_PAD_BYTES       = 3'd4
  } cfg_reg_t;

  typedef logic [MAG_BITS-1:0] cos_tab_t [TAB_SIZE];

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Q30 cosine by a Horner-form Taylor series, evaluated at elaboration only.
  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] sub;
    x2 = (x * x) >> 30;
    r = ONE_Q30;
    for (int k = 7; k >= 1; k--) begin
      sub = ((x2 * r) >> 30) / 64'((2 * k - 1) * (2 * k));
      r = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
    end
    return r;
  endfunction

  function automatic cos_tab_t build_cos_table();
    cos_tab_t    tab;
    logic [63:0] x;
    logic [63:0] c;
    for (int i = 0; i < TAB_SIZE; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) >> TAB_ADDR_BITS;
      c = cos_q30(x);
      tab[i] = MAG_BITS'((c * 64'(AMPLITUDE) + (ONE_Q30 >> 1)) >> 30);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TABLE = build_cos_table();

endpackage

// ===== design/bfsk_if.sv =====
// Handshake channel interfaces of the binary FSK tone modulator.
interface bfsk_in_if import bfsk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [BYTE_BITS-1:0] message_byte;

  modport source (output valid, output kind, output message_byte, input ready);
  modport sink (input valid, input kind, input message_byte, output ready);
endinterface

interface bfsk_out_if import bfsk_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          byte_wanted;
  logic                          underrun;
  logic                          last_of_byte;

  modport source (output valid, output sample, output byte_wanted, output underrun,
                  output last_of_byte, input ready);
  modport sink (input valid, input sample, input byte_wanted, input underrun,
                input last_of_byte, output ready);
endinterface

interface bfsk_cfg_if import bfsk_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/binary_fsk_tone_modulator.sv =====
// Binary FSK tone modulator: preamble, then message bytes MSB first as mark and space tones.
// Takes one item per clock cycle. A tick item yields one sample item in the cycle after it
// is accepted; a load item yields nothing. The sample comes from the state registers
// through one phase select, one cosine table read and a negation into the result
// register. The input stalls only while a result waits and the receiver is not ready,
// so with a receiver that is always ready items follow with no gap. Configuration
// writes are accepted in every cycle.
module binary_fsk_tone_modulator import bfsk_pkg::*; (
  input logic         clk,
  input logic         rst,
  bfsk_in_if.sink     items,
  bfsk_out_if.source  results,
  bfsk_cfg_if.sink    cfg
);

  logic [PHASE_BITS-1:0] pad_step;
  logic [PHASE_BITS-1:0] space_step;
  logic [PHASE_BITS-1:0] mark_step;
  logic [SPB_BITS-1:0]   samples_per_bit;

  logic [PHASE_BITS-1:0] pad_phase;
  logic [PHASE_BITS-1:0] space_phase;
  logic [PHASE_BITS-1:0] mark_phase;
  logic [SPB_BITS-1:0]   sample_in_bit;
  logic [2:0]            bit_position;
  logic [PAD_BITS-1:0]   preamble_left;
  logic [BYTE_BITS-1:0]  current_byte;
  logic [BYTE_BITS-1:0]  holding_byte;
  logic                  holding_full;
  logic                  current_valid;

  logic                          in_accept;
  logic                          in_preamble;
  logic                          take;
  logic [BYTE_BITS-1:0]          byte_eff;
  logic                          under;
  logic                          cur_bit;
  logic [PHASE_BITS-1:0]         sel_phase;
  logic [1:0]                    quadrant;
  logic [TAB_ADDR_BITS-1:0]      tab_k;
  logic [TAB_ADDR_BITS-1:0]      tab_addr;
  logic [MAG_BITS-1:0]           mag;
  logic signed [SAMPLE_BITS-1:0] tone;
  logic                          bit_end;
  logic                          slot_end;

  assign in_accept   = items.valid && items.ready;
  assign items.ready = !results.valid || results.ready;
  assign cfg.ready   = 1'b1;

  assign in_preamble = preamble_left != '0;
  assign take        = !in_preamble && !current_valid && holding_full;
  assign byte_eff    = take ? holding_byte : current_byte;
  assign under       = !in_preamble && !current_valid && !holding_full;
  assign cur_bit     = byte_eff[bit_position];

  always_comb begin
    if (in_preamble) begin
      sel_phase = pad_phase;
    end else if (cur_bit) begin
      sel_phase = mark_phase;
    end else begin
      sel_phase = space_phase;
    end
  end

  // Odd quadrants read the table mirrored; their zero index is the zero crossing.
  assign quadrant = sel_phase[PHASE_BITS-1 -: 2];
  assign tab_k    = sel_phase[PHASE_BITS-3 -: TAB_ADDR_BITS];
  assign tab_addr = quadrant[0] ? TAB_ADDR_BITS'(-tab_k) : tab_k;
  assign mag      = (quadrant[0] && tab_k == '0) ? '0 : COS_TABLE[tab_addr];
  assign tone     = (quadrant[0] ^ quadrant[1]) ? -$signed({1'b0, mag})
                                                : $signed({1'b0, mag});

  assign bit_end  = ({1'b0, sample_in_bit} + 17'd1) >= {1'b0, samples_per_bit};
  assign slot_end = bit_end && bit_position == 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_step        <= PAD_STEP_RST;
      space_step      <= SPACE_STEP_RST;
      mark_step       <= MARK_STEP_RST;
      samples_per_bit <= SPB_RST;
      pad_phase       <= '0;
      space_phase     <= '0;
      mark_phase      <= '0;
      sample_in_bit   <= '0;
      bit_position    <= 3'd7;
      preamble_left   <= PAD_BYTES_RST;
      current_byte    <= '0;
      holding_full    <= 1'b0;
      current_valid   <= 1'b0;
      results.valid   <= 1'b0;
    end else begin
      if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (in_accept && items.kind == KIND_LOAD) begin
        holding_byte <= items.message_byte;
        holding_full <= 1'b1;
      end
      if (in_accept && items.kind == KIND_TICK) begin
        if (take) begin
          current_byte  <= holding_byte;
          current_valid <= 1'b1;
          holding_full  <= 1'b0;
        end
        if (!under) begin
          sample_in_bit <= bit_end ? '0 : sample_in_bit + 16'd1;
          if (bit_end) begin
            bit_position <= bit_position - 3'd1;
          end
          if (slot_end) begin
            if (in_preamble) begin
              preamble_left <= preamble_left - 8'd1;
            end else begin
              current_valid <= 1'b0;
            end
          end
        end
        pad_phase            <= pad_phase + pad_step;
        space_phase          <= space_phase + space_step;
        mark_phase           <= mark_phase + mark_step;
        results.valid        <= 1'b1;
        results.sample       <= under ? '0 : tone;
        results.byte_wanted  <= !(holding_full && !take);
        results.underrun     <= under;
        results.last_of_byte <= slot_end && !under;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PAD_STEP:        pad_step <= cfg.data;
          REG_SPACE_STEP:      space_step <= cfg.data;
          REG_MARK_STEP:       mark_step <= cfg.data;
          REG_SAMPLES_PER_BIT: samples_per_bit <= cfg.data[SPB_BITS-1:0];
          REG_PAD_BYTES:       preamble_left <= cfg.data[PAD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/bfsk_checker.sv =====
// Port-level assertions of the binary FSK tone modulator and their binding.
module bfsk_checker import bfsk_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic                          out_byte_wanted,
  input logic                          out_underrun,
  input logic                          out_last_of_byte
);

  // A new result appears only after a tick item was taken.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_kind == KIND_TICK))
    else $error("result appeared without an accepted tick item");

  // An underrun result is silent, ends no slot, and leaves the holding register empty.
  a_underrun_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_underrun |-> out_sample == '0 && !out_last_of_byte && out_byte_wanted)
    else $error("underrun result carries a sample, slot end or full holding register");

  // With no result pending the block is always ready for a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while no result is pending");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) &&
      $stable(out_byte_wanted) && $stable(out_underrun) && $stable(out_last_of_byte))
    else $error("stalled result changed");

endmodule

bind binary_fsk_tone_modulator bfsk_checker u_bfsk_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (items.valid),
  .in_ready         (items.ready),
  .in_kind          (items.kind),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .out_sample       (results.sample),
  .out_byte_wanted  (results.byte_wanted),
  .out_underrun     (results.underrun),
  .out_last_of_byte (results.last_of_byte)
);
